// ===== sv/bprq_pkg.sv =====
// ----------------------------------------------------------------------------
// bprq_pkg
// Shared types and constants for the bitmap priority run queue.
// ----------------------------------------------------------------------------
package bprq_pkg;

    localparam int NUM_PRIORITIES = 16;
    localparam int NUM_GROUPS     = 8;
    localparam int NUM_THREADS    = 64;

    localparam int PW = $clog2(NUM_PRIORITIES);
    localparam int GW = $clog2(NUM_GROUPS);
    localparam int TW = $clog2(NUM_THREADS);
    localparam int LW = TW + 1;
    localparam int CW = TW + 1;
    localparam int FW = 1 + PW + GW;

    localparam logic [LW-1:0] NIL = LW'(NUM_THREADS);

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_PICK   = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADTID = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CMD_IDLE,
        CMD_LOAD,
        CMD_FETCH,
        CMD_READ,
        CMD_COMMIT
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
    } ctl_t;

endpackage

// ===== sv/bitmap_priority_runqueue.sv =====
// ----------------------------------------------------------------------------
// bitmap_priority_runqueue
// Two-level bitmap run queue with active and expired halves.
// Requests pass through the load, head/place read, link read and commit steps,
// and a new request is taken only after the last one has committed; the result
// strobe is registered after the commit step.
// Reset: asynchronous, all queues empty, active queue is the first.
// Results are shown for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module bitmap_priority_runqueue
    import bprq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] op,
    input  logic       queue_sel,
    input  logic [5:0] thread_id,
    input  logic [3:0] priority_req,
    input  logic [2:0] group,
    output logic       done,
    output logic [1:0] status,
    output logic [5:0] picked_thread,
    output logic [3:0] picked_priority,
    output logic [2:0] picked_group,
    output logic       swapped,
    output logic [6:0] active_count
);

    ctl_t ctl;

    bprq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctl   (ctl)
    );

    bprq_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .op              (op),
        .queue_sel       (queue_sel),
        .thread_id       (thread_id),
        .priority_req    (priority_req),
        .group           (group),
        .status          (status),
        .picked_thread   (picked_thread),
        .picked_priority (picked_priority),
        .picked_group    (picked_group),
        .swapped         (swapped),
        .active_count    (active_count)
    );

endmodule

// ===== sv/bprq_datapath.sv =====
// ----------------------------------------------------------------------------
// bprq_datapath
// Run queue storage, link memories and the add, remove and pick update.
// ----------------------------------------------------------------------------
module bprq_datapath
    import bprq_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  ctl_t          ctl,
    input  logic [1:0]    op,
    input  logic          queue_sel,
    input  logic [5:0]    thread_id,
    input  logic [3:0]    priority_req,
    input  logic [2:0]    group,
    output logic [1:0]    status,
    output logic [5:0]    picked_thread,
    output logic [3:0]    picked_priority,
    output logic [2:0]    picked_group,
    output logic          swapped,
    output logic [6:0]    active_count
);

    localparam int NF = 2 * NUM_PRIORITIES * NUM_GROUPS;
    localparam int NP = 2 * NUM_PRIORITIES;

    logic [LW-1:0] head_mem [NF];
    logic [LW-1:0] tail_mem [NF];
    logic [LW-1:0] next_mem [NUM_THREADS];
    logic [LW-1:0] prev_mem [NUM_THREADS];
    logic [FW-1:0] place_mem [NUM_THREADS];
    logic [NF-1:0] fifo_vld_reg;
    logic [NUM_THREADS-1:0] queued_reg;

    logic                      active_is_second_reg;
    logic [NUM_PRIORITIES-1:0] prio_bitmap_reg [2];
    logic [NUM_GROUPS-1:0]     group_bitmap_reg [NP];
    logic [CW-1:0]             prio_count_reg [NP];
    logic [CW-1:0]             queue_total_reg [2];

    logic [1:0]    op_reg;
    logic          q_reg;
    logic [TW-1:0] t_reg;
    logic [PW-1:0] p_reg;
    logic [GW-1:0] g_reg;
    logic          sw_reg;
    logic          fail_reg;
    logic [1:0]    fail_code_reg;

    logic [LW-1:0] head_rd_reg, tail_rd_reg, next_rd_reg, prev_rd_reg;
    logic [FW-1:0] place_rd_reg;

    logic [PW-1:0] low_p;
    logic [GW-1:0] low_g;
    logic          a_now;
    logic [NUM_GROUPS-1:0] gm;

    always_comb
    begin
        a_now = active_is_second_reg ^ (prio_bitmap_reg[active_is_second_reg] == '0);
        low_p = '0;
        for (int i = NUM_PRIORITIES - 1; i >= 0; i--)
        begin
            if (prio_bitmap_reg[a_now][i])
            begin
                low_p = PW'(i);
            end
        end
        gm = group_bitmap_reg[{a_now, low_p}];
        low_g = '0;
        for (int i = NUM_GROUPS - 1; i >= 0; i--)
        begin
            if (gm[i])
            begin
                low_g = GW'(i);
            end
        end
    end

    logic [FW-1:0] fidx;
    assign fidx = {q_reg, p_reg, g_reg};

    logic [LW-1:0] head_v, tail_v;
    assign head_v = fifo_vld_reg[fidx] ? head_rd_reg : NIL;
    assign tail_v = fifo_vld_reg[fidx] ? tail_rd_reg : NIL;

    // link read addresses: remove uses the stored place, pick the fetched head
    logic [FW-1:0] fidx_f;
    logic [TW-1:0] t_f;
    assign fidx_f = (op_reg == OP_REMOVE) ? place_rd_reg : fidx;
    assign t_f    = (op_reg == OP_PICK) ? head_v[TW-1:0] : t_reg;

    always_ff @(posedge clk)
    begin
        unique case (ctl.cmd)
            CMD_READ:
            begin
                place_rd_reg <= place_mem[t_reg];
                head_rd_reg  <= head_mem[fidx];
            end
            CMD_FETCH:
            begin
                head_rd_reg  <= head_mem[fidx_f];
                tail_rd_reg  <= tail_mem[fidx_f];
                next_rd_reg  <= next_mem[t_f];
                prev_rd_reg  <= prev_mem[t_f];
            end
            CMD_COMMIT:
            begin
                if (!fail_reg)
                begin
                    if (op_reg == OP_ADD)
                    begin
                        next_mem[t_reg]  <= NIL;
                        prev_mem[t_reg]  <= tail_v;
                        place_mem[t_reg] <= fidx;
                        if (tail_v == NIL)
                        begin
                            head_mem[fidx] <= LW'(t_reg);
                        end
                        else
                        begin
                            next_mem[tail_v[TW-1:0]] <= LW'(t_reg);
                        end
                        tail_mem[fidx] <= LW'(t_reg);
                    end
                    else
                    begin
                        if (prev_rd_reg == NIL)
                        begin
                            head_mem[fidx] <= next_rd_reg;
                        end
                        else
                        begin
                            next_mem[prev_rd_reg[TW-1:0]] <= next_rd_reg;
                        end
                        if (next_rd_reg == NIL)
                        begin
                            tail_mem[fidx] <= prev_rd_reg;
                        end
                        else
                        begin
                            prev_mem[next_rd_reg[TW-1:0]] <= prev_rd_reg;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_vld_reg         <= '0;
            queued_reg           <= '0;
            active_is_second_reg <= 1'b0;
            for (int i = 0; i < 2; i++)
            begin
                prio_bitmap_reg[i] <= '0;
                queue_total_reg[i] <= '0;
            end
            for (int i = 0; i < NP; i++)
            begin
                group_bitmap_reg[i] <= '0;
                prio_count_reg[i]   <= '0;
            end
            op_reg          <= OP_NOP;
            q_reg           <= 1'b0;
            t_reg           <= '0;
            p_reg           <= '0;
            g_reg           <= '0;
            sw_reg          <= 1'b0;
            fail_reg        <= 1'b0;
            fail_code_reg   <= ST_OK;
            status          <= ST_OK;
            picked_thread   <= '0;
            picked_priority <= '0;
            picked_group    <= '0;
            swapped         <= 1'b0;
            active_count    <= '0;
        end
        else
        begin
            unique case (ctl.cmd)
                CMD_LOAD:
                begin
                    op_reg <= op;
                    sw_reg <= 1'b0;
                    fail_reg <= 1'b0;
                    fail_code_reg <= ST_OK;
                    unique case (op)
                        OP_ADD:
                        begin
                            q_reg <= queue_sel ^ active_is_second_reg;
                            t_reg <= TW'(thread_id);
                            p_reg <= PW'(priority_req);
                            g_reg <= GW'(group);
                            if (queued_reg[thread_id[TW-1:0]])
                            begin
                                fail_reg <= 1'b1;
                                fail_code_reg <= ST_BADTID;
                            end
                        end
                        OP_REMOVE:
                        begin
                            q_reg <= queue_sel ^ active_is_second_reg;
                            t_reg <= TW'(thread_id);
                            if (!queued_reg[thread_id[TW-1:0]])
                            begin
                                fail_reg <= 1'b1;
                                fail_code_reg <= ST_BADTID;
                            end
                        end
                        OP_PICK:
                        begin
                            active_is_second_reg <= a_now;
                            sw_reg <= (prio_bitmap_reg[active_is_second_reg] == '0);
                            q_reg  <= a_now;
                            p_reg  <= low_p;
                            g_reg  <= low_g;
                            if (prio_bitmap_reg[a_now] == '0)
                            begin
                                fail_reg <= 1'b1;
                                fail_code_reg <= ST_EMPTY;
                            end
                        end
                        default:
                        begin
                            fail_reg <= 1'b1;
                        end
                    endcase
                end
                CMD_FETCH:
                begin
                    if (op_reg == OP_REMOVE && !fail_reg)
                    begin
                        {p_reg, g_reg} <= place_rd_reg[PW+GW-1:0];
                        if (place_rd_reg[FW-1] != q_reg)
                        begin
                            fail_reg <= 1'b1;
                            fail_code_reg <= ST_BADTID;
                        end
                    end
                    if (op_reg == OP_PICK)
                    begin
                        t_reg <= head_v[TW-1:0];
                    end
                end
                CMD_COMMIT:
                begin
                    status          <= fail_code_reg;
                    swapped         <= sw_reg;
                    picked_thread   <= '0;
                    picked_priority <= '0;
                    picked_group    <= '0;
                    active_count    <= 7'(queue_total_reg[active_is_second_reg]);
                    if (!fail_reg)
                    begin
                        if (op_reg == OP_ADD)
                        begin
                            queued_reg[t_reg] <= 1'b1;
                            fifo_vld_reg[fidx] <= 1'b1;
                            group_bitmap_reg[{q_reg, p_reg}][g_reg] <= 1'b1;
                            prio_count_reg[{q_reg, p_reg}] <=
                                prio_count_reg[{q_reg, p_reg}] + 1'b1;
                            prio_bitmap_reg[q_reg][p_reg] <= 1'b1;
                            queue_total_reg[q_reg] <= queue_total_reg[q_reg] + 1'b1;
                            if (q_reg == active_is_second_reg)
                            begin
                                active_count <= 7'(queue_total_reg[q_reg] + 1'b1);
                            end
                        end
                        else
                        begin
                            queued_reg[t_reg] <= 1'b0;
                            fifo_vld_reg[fidx] <= 1'b1;
                            if (prev_rd_reg == NIL && next_rd_reg == NIL)
                            begin
                                group_bitmap_reg[{q_reg, p_reg}][g_reg] <= 1'b0;
                            end
                            prio_count_reg[{q_reg, p_reg}] <=
                                prio_count_reg[{q_reg, p_reg}] - 1'b1;
                            if (prio_count_reg[{q_reg, p_reg}] == CW'(1))
                            begin
                                prio_bitmap_reg[q_reg][p_reg] <= 1'b0;
                            end
                            queue_total_reg[q_reg] <= queue_total_reg[q_reg] - 1'b1;
                            if (q_reg == active_is_second_reg)
                            begin
                                active_count <= 7'(queue_total_reg[q_reg] - 1'b1);
                            end
                            if (op_reg == OP_PICK)
                            begin
                                picked_thread   <= 6'(t_reg);
                                picked_priority <= 4'(p_reg);
                                picked_group    <= 3'(g_reg);
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

// ===== sv/bprq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bprq_ctrl
// Request sequencer: load, head/place read, link read, commit.
// ----------------------------------------------------------------------------
module bprq_ctrl
    import bprq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    output logic done,
    output ctl_t ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_FETCH,
        S_COMMIT
    } state_t;

    state_t state_reg;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:   ctl.cmd = start ? CMD_LOAD : CMD_IDLE;
            S_READ:   ctl.cmd = CMD_READ;
            S_FETCH:  ctl.cmd = CMD_FETCH;
            S_COMMIT: ctl.cmd = CMD_COMMIT;
            default:  ctl.cmd = CMD_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done      <= 1'b0;
        end
        else
        begin
            done <= (state_reg == S_COMMIT);
            unique case (state_reg)
                S_IDLE:   state_reg <= start ? S_READ : S_IDLE;
                S_READ:   state_reg <= S_FETCH;
                S_FETCH:  state_reg <= S_COMMIT;
                S_COMMIT: state_reg <= S_IDLE;
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== sim/tb_bitmap_priority_runqueue.sv =====
// ----------------------------------------------------------------------------
// tb_bitmap_priority_runqueue
// Self-checking bench for the two-level bitmap run queue: a directed table,
// then random add, remove, pick and no-op requests checked against a behavioral
// model of both queues, with random idle gaps on the request side.
// ----------------------------------------------------------------------------
module tb_bitmap_priority_runqueue
    import bprq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_RANDOM     = 400;

    typedef struct {
        logic [1:0] op;
        logic       sel;
        logic [5:0] tid;
        logic [3:0] prio;
        logic [2:0] grp;
        logic       known;
        logic [1:0] k_status;
        logic [6:0] k_count;
    } req_row_t;

    typedef struct {
        logic [1:0] status;
        logic [5:0] thread;
        logic [3:0] prio;
        logic [2:0] grp;
        logic       swapped;
        logic [6:0] count;
    } sched_out_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] op;
    logic       queue_sel;
    logic [5:0] thread_id;
    logic [3:0] priority_req;
    logic [2:0] group;
    logic       done;
    logic [1:0] status;
    logic [5:0] picked_thread;
    logic [3:0] picked_priority;
    logic [2:0] picked_group;
    logic       swapped;
    logic [6:0] active_count;

    bitmap_priority_runqueue dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .queue_sel(queue_sel), .thread_id(thread_id), .priority_req(priority_req),
        .group(group), .done(done), .status(status), .picked_thread(picked_thread),
        .picked_priority(picked_priority), .picked_group(picked_group),
        .swapped(swapped), .active_count(active_count)
    );

    // scheduler model: FIFOs kept as queues of thread ids
    logic       m_active;
    int         m_fifo[2][NUM_PRIORITIES][NUM_GROUPS][$];
    logic       m_queued[NUM_THREADS];
    logic       m_q[NUM_THREADS];
    int         m_p[NUM_THREADS];
    int         m_g[NUM_THREADS];
    int         m_total[2];

    sched_out_t expected_q[$];
    req_row_t   known_q[$];
    int         errors;
    int         idle_cycles;
    int         quiet_stretch;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int q_empty(int q);
        return int'(m_total[q] == 0);
    endfunction

    function automatic void sched_unlink(int t);
        int q;
        int p;
        int g;
        q = int'(m_q[t]);
        p = m_p[t];
        g = m_g[t];
        for (int i = 0; i < m_fifo[q][p][g].size(); i++)
        begin
            if (m_fifo[q][p][g][i] == t)
            begin
                m_fifo[q][p][g].delete(i);
                break;
            end
        end
        m_queued[t] = 1'b0;
        m_total[q]--;
    endfunction

    function automatic sched_out_t sched_predict(req_row_t r);
        sched_out_t o;
        int phys;
        int a;
        int t;
        bit found;
        o = '{default: '0};
        phys = int'(r.sel ^ m_active);
        case (op_t'(r.op))
            OP_ADD:
            begin
                if (m_queued[r.tid])
                    o.status = ST_BADTID;
                else
                begin
                    m_fifo[phys][r.prio][r.grp].push_back(int'(r.tid));
                    m_queued[r.tid] = 1'b1;
                    m_q[r.tid] = 1'(phys);
                    m_p[r.tid] = int'(r.prio);
                    m_g[r.tid] = int'(r.grp);
                    m_total[phys]++;
                end
            end
            OP_REMOVE:
            begin
                if (!m_queued[r.tid] || int'(m_q[r.tid]) != phys)
                    o.status = ST_BADTID;
                else
                    sched_unlink(int'(r.tid));
            end
            OP_PICK:
            begin
                if (q_empty(int'(m_active)) != 0)
                begin
                    m_active = ~m_active;
                    o.swapped = 1'b1;
                end
                a = int'(m_active);
                found = 0;
                for (int p = 0; p < NUM_PRIORITIES && !found; p++)
                    for (int g = 0; g < NUM_GROUPS && !found; g++)
                        if (m_fifo[a][p][g].size() != 0)
                        begin
                            found = 1;
                            t = m_fifo[a][p][g][0];
                            sched_unlink(t);
                            o.thread = 6'(t);
                            o.prio = 4'(p);
                            o.grp = 3'(g);
                        end
                if (!found)
                    o.status = ST_EMPTY;
            end
            default: ;
        endcase
        o.count = 7'(m_total[m_active]);
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        sched_out_t e;
        req_row_t   k;
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                e = expected_q.pop_front();
                k = known_q.pop_front();
                if (status !== e.status)
                    report_mismatch("status", int'(status), int'(e.status));
                if (picked_thread !== e.thread)
                    report_mismatch("picked_thread", int'(picked_thread), int'(e.thread));
                if (picked_priority !== e.prio)
                    report_mismatch("picked_priority", int'(picked_priority), int'(e.prio));
                if (picked_group !== e.grp)
                    report_mismatch("picked_group", int'(picked_group), int'(e.grp));
                if (swapped !== e.swapped)
                    report_mismatch("swapped", int'(swapped), int'(e.swapped));
                if (active_count !== e.count)
                    report_mismatch("active_count", int'(active_count), int'(e.count));
                if (k.known)
                begin
                    if (status !== k.k_status)
                        report_mismatch("status (table)", int'(status), int'(k.k_status));
                    if (active_count !== k.k_count)
                        report_mismatch("active_count (table)", int'(active_count),
                                        int'(k.k_count));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("tb_bitmap_priority_runqueue: FAIL");
        $finish;
    end

    task automatic send(req_row_t r);
        bit gap;
        gap = (quiet_stretch == 0) && ($urandom_range(0, 99) < 15);
        while (gap)
        begin
            start <= 1'b0;
            @(posedge clk);
            gap = $urandom_range(0, 99) < 15;
        end
        start <= 1'b1;
        op <= r.op;
        queue_sel <= r.sel;
        thread_id <= r.tid;
        priority_req <= r.prio;
        group <= r.grp;
        @(posedge clk);
        while (busy) @(posedge clk);
        expected_q.push_back(sched_predict(r));
        known_q.push_back(r);
        if (quiet_stretch > 0) quiet_stretch--;
    endtask

    function automatic req_row_t mk(logic [1:0] o, logic s, logic [5:0] t,
                                    logic [3:0] p, logic [2:0] g);
        req_row_t r;
        r = '{op: o, sel: s, tid: t, prio: p, grp: g, known: 1'b0,
              k_status: '0, k_count: '0};
        return r;
    endfunction

    function automatic req_row_t mkk(logic [1:0] o, logic s, logic [5:0] t, logic [3:0] p,
                                     logic [2:0] g, logic [1:0] ks, logic [6:0] kc);
        req_row_t r;
        r = mk(o, s, t, p, g);
        r.known = 1'b1;
        r.k_status = ks;
        r.k_count = kc;
        return r;
    endfunction

    req_row_t directed[$];

    initial
    begin
        req_row_t r;
        int pool;
        int kind;
        errors = 0;
        idle_cycles = 0;
        quiet_stretch = 0;
        m_active = 1'b0;
        m_total = '{0, 0};
        for (int i = 0; i < NUM_THREADS; i++)
        begin
            m_queued[i] = 1'b0;
            m_q[i] = 1'b0;
            m_p[i] = 0;
            m_g[i] = 0;
        end
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_NOP;
        queue_sel = 1'b0;
        thread_id = '0;
        priority_req = '0;
        group = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = '{
            mkk(OP_PICK,   1'b0, 6'd0,  4'd0,  3'd0, ST_EMPTY,  7'd0),
            mkk(OP_REMOVE, 1'b0, 6'd5,  4'd0,  3'd0, ST_BADTID, 7'd0),
            mkk(OP_ADD,    1'b0, 6'd63, 4'd15, 3'd7, ST_OK,     7'd1),
            mkk(OP_ADD,    1'b0, 6'd63, 4'd0,  3'd0, ST_BADTID, 7'd1),
            mkk(OP_ADD,    1'b0, 6'd0,  4'd0,  3'd0, ST_OK,     7'd2),
            mk(OP_ADD,     1'b0, 6'd1,  4'd0,  3'd0),
            mk(OP_ADD,     1'b0, 6'd2,  4'd0,  3'd0),
            mk(OP_ADD,     1'b1, 6'd42, 4'd10, 3'd5),
            mk(OP_ADD,     1'b1, 6'd21, 4'd5,  3'd2),
            mkk(OP_REMOVE, 1'b0, 6'd42, 4'd0,  3'd0, ST_BADTID, 7'd4),
            mkk(OP_NOP,    1'b1, 6'd63, 4'd15, 3'd7, ST_OK,     7'd4),
            mk(OP_REMOVE,  1'b0, 6'd1,  4'd0,  3'd0),
            mk(OP_PICK,    1'b0, 6'd0,  4'd0,  3'd0),
            mk(OP_PICK,    1'b0, 6'd0,  4'd0,  3'd0),
            mk(OP_PICK,    1'b0, 6'd0,  4'd0,  3'd0),
            mk(OP_PICK,    1'b0, 6'd0,  4'd0,  3'd0),
            mk(OP_PICK,    1'b0, 6'd0,  4'd0,  3'd0),
            mk(OP_PICK,    1'b0, 6'd0,  4'd0,  3'd0),
            mk(OP_REMOVE,  1'b1, 6'd0,  4'd0,  3'd0),
            mk(OP_PICK,    1'b1, 6'd0,  4'd0,  3'd0)
        };
        foreach (directed[i])
            send(directed[i]);

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n == 150)
                quiet_stretch = 100;
            pool = (n % 200 < 100) ? 12 : 64;
            kind = $urandom_range(0, 99);
            r = mk(OP_ADD, 1'($urandom_range(0, 1)), 6'($urandom_range(0, pool - 1)),
                   4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)));
            if (kind < 5)
            begin
                r.tid = 6'($urandom_range(0, 63));
                r.prio = $urandom_range(0, 1) ? 4'd15 : 4'd0;
                r.grp = $urandom_range(0, 1) ? 3'd7 : 3'd0;
            end
            if (kind < 40)
                r.op = OP_ADD;
            else if (kind < 65)
                r.op = OP_REMOVE;
            else if (kind < 95)
                r.op = OP_PICK;
            else
                r.op = OP_NOP;
            send(r);
        end
        start <= 1'b0;

        while (expected_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("tb_bitmap_priority_runqueue: PASS");
        else
            $display("tb_bitmap_priority_runqueue: FAIL");
        $finish;
    end
endmodule
